### rtl/pio_pkg.sv
// Shared types and constants for the two-port parallel I/O controller.
// No dependencies; imported by the top level.
package pio_pkg;

   // Access codes carried by req_mode.
   typedef enum logic [2:0] {
      OP_DATA_RD = 3'd0,
      OP_DATA_WR = 3'd1,
      OP_CTRL_RD = 3'd2,
      OP_CTRL_WR = 3'd3,
      OP_RX_BYTE = 3'd4
   } op_type;

   // Bits of the interrupt control nibble.
   localparam int unsigned CTL_MASK_FOLLOWS = 0;
   localparam int unsigned CTL_ENABLE       = 3;

   // Low-nibble codes of a control word.
   localparam logic [3:0] CW_SET_MODE   = 4'hF;
   localparam logic [3:0] CW_SET_INTCTL = 4'h7;
   localparam logic [3:0] CW_SET_ENABLE = 4'h3;

   // Interrupt level of port 0; port n uses LEVEL_BASE + n.
   localparam logic [2:0] LEVEL_BASE = 3'd6;

endpackage

### rtl/parallel_io_port_controller.sv
// Two-port parallel I/O controller: control decode, per-port receive FIFOs
// and interrupt generation. Depends on pio_pkg (rtl/pio_pkg.sv).
//
//   channel   direction  ports                                   handshake
//   req_      in         mode[2:0] port data[7:0]                 valid/stall
//   rsp_      out        read_data[7:0] int_request int_vector[7:0]
//                        int_level[2:0] overflow                  valid/stall
//
// One request per cycle while the response side is not stalled; its response
// appears in the output register in the cycle after acceptance. The FIFO memory
// read port is registered and feeds the response directly.
// Reset clears all port registers, FIFO heads and counts; the FIFO memory
// itself is not cleared, since only written entries are ever read.
// A stalled response holds the output register and stalls the request side.
module parallel_io_port_controller
   import pio_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = 16,
   parameter int unsigned PORT_COUNT = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic       req_port,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_int_request,
   output logic [7:0] rsp_int_vector,
   output logic [2:0] rsp_int_level,
   output logic       rsp_overflow
);

   localparam int unsigned HW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned TW = CW + 1;
   localparam int unsigned PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int unsigned MD = PORT_COUNT * FIFO_DEPTH;
   localparam int unsigned AW = $clog2(MD);

   // Per-port registers
   logic [7:0]    vector_ff   [PORT_COUNT];
   logic [7:0]    vector_in   [PORT_COUNT];
   logic [1:0]    io_mode_ff  [PORT_COUNT];
   logic [1:0]    io_mode_in  [PORT_COUNT];
   logic [3:0]    int_ctl_ff  [PORT_COUNT];
   logic [3:0]    int_ctl_in  [PORT_COUNT];
   logic [7:0]    mask_ff     [PORT_COUNT];
   logic [7:0]    mask_in     [PORT_COUNT];
   logic [HW-1:0] head_ff     [PORT_COUNT];
   logic [HW-1:0] head_in     [PORT_COUNT];
   logic [CW-1:0] count_ff    [PORT_COUNT];
   logic [CW-1:0] count_in    [PORT_COUNT];

   // Receive FIFO storage, all ports in one memory
   logic [7:0]    rx_mem [MD];
   logic [7:0]    rd_q_ff;

   // Response register
   logic          rsp_valid_ff;
   logic          pop_ff;
   logic          irq_ff;
   logic [7:0]    vec_ff;
   logic [2:0]    level_ff;
   logic          ovf_ff;

   // Decode of the current request
   op_type        op;
   logic          accept;
   logic          port_ok;
   logic [PW-1:0] port_sel;
   logic [HW-1:0] head;
   logic [CW-1:0] count;
   logic [3:0]    ictl;
   logic          pop;
   logic          push;
   logic          ovf;
   logic          irq;
   logic [HW:0]   head_inc;
   logic [HW-1:0] head_next;
   logic [TW-1:0] tail_sum;
   logic [HW-1:0] tail;
   logic [CW-1:0] count_after;
   logic [AW-1:0] base;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   // Stall requests only while a response waits to be taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign op       = op_type'(req_mode);
   assign port_sel = PW'(req_port);
   assign port_ok  = (int'(req_port) < int'(PORT_COUNT));

   assign head  = head_ff[port_sel];
   assign count = count_ff[port_sel];
   assign ictl  = int_ctl_ff[port_sel];

   always_comb begin
      pop  = accept && port_ok && (op == OP_DATA_RD) && (count != '0);
      push = accept && port_ok && (op == OP_RX_BYTE) && (count != CW'(FIFO_DEPTH));
      ovf  = accept && port_ok && (op == OP_RX_BYTE) && (count == CW'(FIFO_DEPTH));

      // Advance the read index with wrap.
      head_inc  = {1'b0, head} + (HW + 1)'(1);
      head_next = (head_inc >= (HW + 1)'(FIFO_DEPTH)) ? '0 : head_inc[HW-1:0];

      // Write index: head plus count, folded once.
      tail_sum = TW'(head) + TW'(count);
      if (tail_sum >= TW'(FIFO_DEPTH)) begin
         tail_sum = tail_sum - TW'(FIFO_DEPTH);
      end
      tail = tail_sum[HW-1:0];

      count_after = count;
      if (push) begin
         count_after = count + CW'(1);
      end else if (pop) begin
         count_after = count - CW'(1);
      end

      irq = accept && port_ok && ((op == OP_DATA_RD) || (op == OP_RX_BYTE))
            && (count_after != '0) && ictl[CTL_ENABLE];

      base    = (port_sel != '0) ? AW'(FIFO_DEPTH) : '0;
      rd_addr = base + AW'(head);
      wr_addr = base + AW'(tail);
   end

   // Next state of the per-port registers.
   always_comb begin
      for (int i = 0; i < int'(PORT_COUNT); i++) begin
         vector_in[i]  = vector_ff[i];
         io_mode_in[i] = io_mode_ff[i];
         int_ctl_in[i] = int_ctl_ff[i];
         mask_in[i]    = mask_ff[i];
         head_in[i]    = head_ff[i];
         count_in[i]   = count_ff[i];
      end

      if (pop) begin
         head_in[port_sel] = head_next;
      end
      count_in[port_sel] = count_after;

      // Control word decode, first match wins.
      if (accept && port_ok && (op == OP_CTRL_WR)) begin
         if (ictl[CTL_MASK_FOLLOWS]) begin
            mask_in[port_sel]                      = req_data;
            int_ctl_in[port_sel][CTL_MASK_FOLLOWS] = 1'b0;
         end else if (!req_data[0]) begin
            vector_in[port_sel] = req_data;
         end else if (req_data[3:0] == CW_SET_MODE) begin
            io_mode_in[port_sel] = req_data[7:6];
         end else if (req_data[3:0] == CW_SET_INTCTL) begin
            int_ctl_in[port_sel] = req_data[7:4];
         end else if (req_data[3:0] == CW_SET_ENABLE) begin
            int_ctl_in[port_sel][CTL_ENABLE] = req_data[7];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(PORT_COUNT); i++) begin
            vector_ff[i]  <= '0;
            io_mode_ff[i] <= '0;
            int_ctl_ff[i] <= '0;
            mask_ff[i]    <= '0;
            head_ff[i]    <= '0;
            count_ff[i]   <= '0;
         end
      end else begin
         for (int i = 0; i < int'(PORT_COUNT); i++) begin
            vector_ff[i]  <= vector_in[i];
            io_mode_ff[i] <= io_mode_in[i];
            int_ctl_ff[i] <= int_ctl_in[i];
            mask_ff[i]    <= mask_in[i];
            head_ff[i]    <= head_in[i];
            count_ff[i]   <= count_in[i];
         end
      end
   end

   // FIFO memory: write on push, registered read at the head on every accept.
   always_ff @(posedge clock) begin
      if (push) begin
         rx_mem[wr_addr] <= req_data;
      end
      if (accept) begin
         rd_q_ff <= rx_mem[rd_addr];
      end
   end

   // Response valid: set on accept, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload: hold while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         pop_ff   <= pop;
         irq_ff   <= irq;
         vec_ff   <= irq ? vector_ff[port_sel] : 8'h00;
         level_ff <= irq ? (LEVEL_BASE + 3'(req_port)) : 3'd0;
         ovf_ff   <= ovf;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = pop_ff ? rd_q_ff : 8'h00;
   assign rsp_int_request = irq_ff;
   assign rsp_int_vector  = vec_ff;
   assign rsp_int_level   = level_ff;
   assign rsp_overflow    = ovf_ff;

   // Checks
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_int_request) |->
         ((rsp_int_level == LEVEL_BASE) || (rsp_int_level == LEVEL_BASE + 3'd1)))
      else $error("interrupt level out of range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_read_data == 8'h00))
      else $error("overflow response carries read data");

   assert property (@(posedge clock) disable iff (reset)
      ovf |=> (count_ff[$past(port_sel)] == CW'(FIFO_DEPTH)))
      else $error("overflow flagged but FIFO count changed");

   assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CW'(FIFO_DEPTH))
      else $error("FIFO count exceeds depth");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for the two-port parallel I/O controller: directed and random requests
// checked against an in-bench model of the port state. Depends on pio_pkg and the top level.
module tb;
   import pio_pkg::*;

   localparam int unsigned DEPTH       = 16;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          HOLD_CYCLES = 120;

   // One response, field by field as the block presents it.
   typedef struct packed {
      logic [7:0] read_data;
      logic       int_request;
      logic [7:0] int_vector;
      logic [2:0] int_level;
      logic       overflow;
   } pio_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode = '0;
   logic       req_port = 1'b0;
   logic [7:0] req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_int_request;
   logic [7:0] rsp_int_vector;
   logic [2:0] rsp_int_level;
   logic       rsp_overflow;

   // Model of the port state, updated at each accepted request.
   logic [7:0] port_vector [2];
   logic [1:0] port_io_mode [2];
   logic [3:0] port_int_ctl [2];
   logic [7:0] port_mask [2];
   logic [7:0] rx_bytes [2][DEPTH];
   logic [3:0] rx_rd_ptr [2];
   logic [4:0] rx_level [2];

   pio_rsp_type due_responses [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_asks     = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   parallel_io_port_controller i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_port        (req_port),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_int_request (rsp_int_request),
      .rsp_int_vector  (rsp_int_vector),
      .rsp_int_level   (rsp_int_level),
      .rsp_overflow    (rsp_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Advance the model by one request and return the response it must produce.
   function automatic pio_rsp_type apply_access(op_type op, logic p, logic [7:0] d);
      pio_rsp_type r;
      logic        irq_check;
      r = '0;
      irq_check = 1'b0;
      case (op)
         OP_DATA_RD: begin
            // Pop only when something is queued; an empty read returns zero.
            if (rx_level[p] != 0) begin
               r.read_data  = rx_bytes[p][rx_rd_ptr[p]];
               rx_rd_ptr[p] = rx_rd_ptr[p] + 4'd1;
               rx_level[p]  = rx_level[p] - 5'd1;
            end
            irq_check = 1'b1;
         end
         OP_CTRL_WR: begin
            // Walk the control word decode in its fixed priority order.
            if (port_int_ctl[p][CTL_MASK_FOLLOWS]) begin
               port_mask[p] = d;
               port_int_ctl[p][CTL_MASK_FOLLOWS] = 1'b0;
            end else if (!d[0]) begin
               port_vector[p] = d;
            end else if (d[3:0] == CW_SET_MODE) begin
               port_io_mode[p] = d[7:6];
            end else if (d[3:0] == CW_SET_INTCTL) begin
               port_int_ctl[p] = d[7:4];
            end else if (d[3:0] == CW_SET_ENABLE) begin
               port_int_ctl[p][CTL_ENABLE] = d[7];
            end
         end
         OP_RX_BYTE: begin
            // Drop the byte and flag it when the queue is full.
            if (rx_level[p] == DEPTH) begin
               r.overflow = 1'b1;
            end else begin
               rx_bytes[p][rx_rd_ptr[p] + rx_level[p][3:0]] = d;
               rx_level[p] = rx_level[p] + 5'd1;
            end
            irq_check = 1'b1;
         end
         default: ;
      endcase
      if (irq_check && rx_level[p] != 0 && port_int_ctl[p][CTL_ENABLE]) begin
         r.int_request = 1'b1;
         r.int_vector  = port_vector[p];
         r.int_level   = LEVEL_BASE + p;
      end
      return r;
   endfunction

   // Offer one request, hold it until accepted, then idle at random.
   task automatic send_access(op_type op, logic p, logic [7:0] d);
      req_valid <= 1'b1;
      req_mode  <= op;
      req_port  <= p;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_responses.push_back(apply_access(op, p, d));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic wait_responses_done();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_responses.size() != 0);
   endtask

   // Pick a control byte that lands in each branch of the decode.
   function automatic logic [7:0] random_ctrl_byte();
      logic [7:0] b;
      b = 8'($urandom);
      case ($urandom_range(4))
         0: b[0] = 1'b0;
         1: b[3:0] = CW_SET_MODE;
         2: b[3:0] = CW_SET_INTCTL;
         3: b[3:0] = CW_SET_ENABLE;
         default: ;
      endcase
      return b;
   endfunction

   task automatic test_control_decode();
      send_access(OP_DATA_RD, 1'b0, 8'h00);   // read with empty queue
      send_access(OP_DATA_WR, 1'b0, 8'hFF);   // no effect
      send_access(OP_CTRL_RD, 1'b1, 8'hAA);   // no effect
      send_access(OP_CTRL_WR, 1'b0, 8'hFE);   // vector, high extreme
      send_access(OP_CTRL_WR, 1'b1, 8'h80);   // vector
      send_access(OP_CTRL_WR, 1'b0, 8'hCF);   // io mode 3
      send_access(OP_CTRL_WR, 1'b0, 8'h05);   // ignored
      send_access(OP_CTRL_WR, 1'b0, 8'h97);   // enable and mask follows
      send_access(OP_CTRL_WR, 1'b0, 8'hFF);   // taken as the mask
      send_access(OP_CTRL_WR, 1'b1, 8'h83);   // enable bit only
      send_access(OP_RX_BYTE, 1'b0, 8'hFF);
      send_access(OP_RX_BYTE, 1'b1, 8'h00);
      send_access(OP_DATA_RD, 1'b0, 8'h00);   // queue drains, no interrupt
      send_access(OP_CTRL_WR, 1'b1, 8'h03);   // clear enable
      send_access(OP_DATA_RD, 1'b1, 8'h00);
   endtask

   task automatic test_rx_overflow();
      // Fill port 0, overrun it once, then pop one byte.
      for (int i = 0; i <= DEPTH; i++) send_access(OP_RX_BYTE, 1'b0, 8'(i * 17));
      send_access(OP_DATA_RD, 1'b0, 8'h00);
   endtask

   // Random traffic built from config sequences, receive and read bursts, and noise.
   task automatic test_random_traffic(int n_items);
      int     done_items;
      int     len;
      logic   p;
      op_type op;
      done_items = 0;
      while (done_items < n_items) begin
         p   = 1'($urandom);
         len = $urandom_range(1, 20);
         case ($urandom_range(9))
            0, 1: begin
               len = $urandom_range(1, 3);
               for (int i = 0; i < len; i++) send_access(OP_CTRL_WR, p, random_ctrl_byte());
            end
            2, 3, 4: for (int i = 0; i < len; i++) send_access(OP_RX_BYTE, p, 8'($urandom));
            5, 6, 7: for (int i = 0; i < len; i++) send_access(OP_DATA_RD, p, 8'($urandom));
            default: begin
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++) begin
                  op = op_type'($urandom_range(OP_RX_BYTE));
                  send_access(op, 1'($urandom), 8'($urandom));
               end
            end
         endcase
         done_items += len;
      end
   endtask

   task automatic test_backpressure();
      // Hold the response side long enough for the block to stall its input.
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_asks++;
      for (int i = 0; i < 40; i++) begin
         send_access(op_type'($urandom_range(OP_RX_BYTE)), 1'($urandom), 8'($urandom));
      end
      wait_responses_done();
   endtask

   // Response side: random stall, plus a long hold whenever one is asked for.
   always @(posedge clock) begin
      if (hold_taken != hold_asks) begin
         hold_taken = hold_asks;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      pio_rsp_type got;
      pio_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_read_data, rsp_int_request, rsp_int_vector, rsp_int_level,
                 rsp_overflow};
         if (due_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: rd=%02h irq=%0d vec=%02h lvl=%0d ovf=%0d",
                        got.read_data, got.int_request, got.int_vector, got.int_level,
                        got.overflow);
         end else begin
            want = due_responses.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: want rd=%02h irq=%0d vec=%02h lvl=%0d ovf=%0d",
                           want.read_data, want.int_request, want.int_vector,
                           want.int_level, want.overflow);
                  $display("           got rd=%02h irq=%0d vec=%02h lvl=%0d ovf=%0d",
                           got.read_data, got.int_request, got.int_vector,
                           got.int_level, got.overflow);
               end
            end
         end
      end
   end

   // Bound the run in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 2; i++) begin
         port_vector[i]  = '0;
         port_io_mode[i] = '0;
         port_int_ctl[i] = '0;
         port_mask[i]    = '0;
         rx_rd_ptr[i]    = '0;
         rx_level[i]     = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_control_decode();
      test_rx_overflow();
      wait_responses_done();

      // Sweep the idle mixes: none, sender only, receiver only, both.
      send_idle_pct = 0;  stall_pct = 0;
      test_random_traffic(350);
      send_idle_pct = 53; stall_pct = 0;
      test_random_traffic(350);
      wait_responses_done();
      send_idle_pct = 0;  stall_pct = 53;
      test_random_traffic(350);
      send_idle_pct = 24; stall_pct = 24;
      test_random_traffic(350);

      test_backpressure();

      // Let any stray response surface before the verdict.
      wait_responses_done();
      repeat (10) @(posedge clock);
      mismatches += due_responses.size();
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
